// ===== hw/rtl/cau_pkg.sv =====
// Shared types, widths and codes for the complex arithmetic unit.
// Depends on nothing; every other file of the unit imports it.
`timescale 1ns / 1ps

package cau_pkg;

    localparam int DATA_W   = 16;
    localparam int FRAC_W   = 8;
    localparam int PROD_W   = 2 * DATA_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int NUM_W    = PROD_W + FRAC_W;
    localparam int QUO_W    = DATA_W + 1;
    localparam int CMP_W    = PROD_W + QUO_W;
    localparam int DIV_STAGES = QUO_W;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_SAT = 2'd2;

    // One result part on its way through the divider. For add, subtract and
    // multiply the finished magnitude rides in rem and the divider leaves it alone.
    typedef struct packed {
        logic              neg;
        logic [NUM_W-1:0]  rem;
        logic [QUO_W-1:0]  quo;
        logic              ovf;
    } cau_part_t;

    typedef struct packed {
        logic              is_div;
        logic              dz;
        logic [PROD_W-1:0] den;
        cau_part_t         re;
        cau_part_t         im;
    } cau_work_t;

    typedef struct packed {
        logic              neg;
        logic [PROD_W-1:0] mag;
    } cau_sm_t;

    function automatic cau_sm_t to_sm(input logic signed [SUM_W-1:0] v);
        cau_sm_t r;
        logic [SUM_W-1:0] m;
        m = v[SUM_W-1] ? (~v + 1'b1) : v;
        r.neg = v[SUM_W-1];
        r.mag = m[PROD_W-1:0];
        return r;
    endfunction

endpackage

// ===== hw/rtl/cau_front.sv =====
// Front end: input register, product stage and combine stage.
// Depends on cau_pkg.
`timescale 1ns / 1ps

module cau_front
    import cau_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_vld,
    input  logic [1:0]               op,
    input  logic signed [DATA_W-1:0] a_re,
    input  logic signed [DATA_W-1:0] a_im,
    input  logic signed [DATA_W-1:0] b_re,
    input  logic signed [DATA_W-1:0] b_im,
    output logic                     out_vld,
    output cau_work_t                out_work
);

    logic                     a_vld_reg;
    logic [1:0]               a_op_reg;
    logic signed [DATA_W-1:0] a_ar_reg, a_ai_reg, a_br_reg, a_bi_reg;

    logic                     p_vld_reg;
    logic [1:0]               p_op_reg;
    logic signed [PROD_W-1:0] p_ac_reg, p_bd_reg, p_ad_reg, p_bc_reg, p_cc_reg, p_dd_reg;
    logic signed [SUM_W-1:0]  p_sre_reg, p_sim_reg;

    logic                     w_vld_reg;
    cau_work_t                w_reg;
    cau_work_t                w_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            p_vld_reg <= 1'b0;
            w_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= in_vld;
            p_vld_reg <= a_vld_reg;
            w_vld_reg <= p_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_op_reg <= op;
            a_ar_reg <= a_re;
            a_ai_reg <= a_im;
            a_br_reg <= b_re;
            a_bi_reg <= b_im;
            p_op_reg <= a_op_reg;
            p_ac_reg <= a_ar_reg * a_br_reg;
            p_bd_reg <= a_ai_reg * a_bi_reg;
            p_ad_reg <= a_ar_reg * a_bi_reg;
            p_bc_reg <= a_ai_reg * a_br_reg;
            p_cc_reg <= a_br_reg * a_br_reg;
            p_dd_reg <= a_bi_reg * a_bi_reg;
            // Add and subtract are ready here; their sums take the same path.
            if (a_op_reg == OP_SUB)
            begin
                p_sre_reg <= SUM_W'(a_ar_reg) - SUM_W'(a_br_reg);
                p_sim_reg <= SUM_W'(a_ai_reg) - SUM_W'(a_bi_reg);
            end
            else
            begin
                p_sre_reg <= SUM_W'(a_ar_reg) + SUM_W'(a_br_reg);
                p_sim_reg <= SUM_W'(a_ai_reg) + SUM_W'(a_bi_reg);
            end
            w_reg <= w_next;
        end
    end

    always_comb
    begin
        logic signed [SUM_W-1:0] nre, nim;
        cau_sm_t                 sre, sim;
        logic [SUM_W-1:0]        fre, fim;
        logic [PROD_W-1:0]       den;
        logic [CMP_W-1:0]        dlim;
        w_next = '0;
        nre = '0;
        nim = '0;
        fre = '0;
        fim = '0;
        case (p_op_reg)
            OP_MUL:
            begin
                nre = SUM_W'(p_ac_reg) - SUM_W'(p_bd_reg);
                nim = SUM_W'(p_ad_reg) + SUM_W'(p_bc_reg);
            end
            OP_DIV:
            begin
                nre = SUM_W'(p_ac_reg) + SUM_W'(p_bd_reg);
                nim = SUM_W'(p_bc_reg) - SUM_W'(p_ad_reg);
            end
            default:
            begin
                nre = p_sre_reg;
                nim = p_sim_reg;
            end
        endcase
        sre = to_sm(nre);
        sim = to_sm(nim);
        den = p_cc_reg[PROD_W-1:0] + p_dd_reg[PROD_W-1:0];
        dlim = {den, {QUO_W{1'b0}}};
        w_next.den = den;
        w_next.re.neg = sre.neg;
        w_next.im.neg = sim.neg;
        if (p_op_reg == OP_DIV)
        begin
            w_next.is_div = 1'b1;
            w_next.dz = (den == '0);
            w_next.re.rem = {sre.mag, {FRAC_W{1'b0}}};
            w_next.im.rem = {sim.mag, {FRAC_W{1'b0}}};
            w_next.re.ovf = CMP_W'(w_next.re.rem) >= dlim;
            w_next.im.ovf = CMP_W'(w_next.im.rem) >= dlim;
        end
        else if (p_op_reg == OP_MUL)
        begin
            // Arithmetic shift right rounds toward minus infinity.
            fre = sre.neg ? ((SUM_W'(sre.mag) + SUM_W'((1 << FRAC_W) - 1)) >> FRAC_W)
                          : (SUM_W'(sre.mag) >> FRAC_W);
            fim = sim.neg ? ((SUM_W'(sim.mag) + SUM_W'((1 << FRAC_W) - 1)) >> FRAC_W)
                          : (SUM_W'(sim.mag) >> FRAC_W);
            w_next.re.rem = NUM_W'(fre);
            w_next.im.rem = NUM_W'(fim);
        end
        else
        begin
            w_next.re.rem = NUM_W'(sre.mag);
            w_next.im.rem = NUM_W'(sim.mag);
        end
    end

    assign out_vld  = w_vld_reg;
    assign out_work = w_reg;

endmodule

// ===== hw/rtl/cau_divider.sv =====
// Restoring divider, one quotient bit per pipeline stage for both result parts.
// Depends on cau_pkg.
`timescale 1ns / 1ps

module cau_divider
    import cau_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      in_vld,
    input  cau_work_t in_work,
    output logic      out_vld,
    output cau_work_t out_work
);

    logic      vld_reg [DIV_STAGES];
    cau_work_t st_reg  [DIV_STAGES];

    function automatic cau_part_t div_step(input cau_part_t p, input logic [PROD_W-1:0] den,
                                           input logic active, input int k);
        cau_part_t r;
        logic [CMP_W-1:0] sh;
        r = p;
        sh = CMP_W'(den) << k;
        if (active && !p.ovf && (CMP_W'(p.rem) >= sh))
        begin
            r.rem = p.rem - sh[NUM_W-1:0];
            r.quo[k] = 1'b1;
        end
        return r;
    endfunction

    genvar i;
    generate
        for (i = 0; i < DIV_STAGES; i++)
        begin : g_stage
            localparam int K = DIV_STAGES - 1 - i;
            logic      v_in;
            cau_work_t w_in;
            cau_work_t w_next;
            if (i == 0)
            begin : g_first
                assign v_in = in_vld;
                assign w_in = in_work;
            end
            else
            begin : g_rest
                assign v_in = vld_reg[i-1];
                assign w_in = st_reg[i-1];
            end
            always_comb
            begin
                w_next = w_in;
                w_next.re = div_step(w_in.re, w_in.den, w_in.is_div, K);
                w_next.im = div_step(w_in.im, w_in.den, w_in.is_div, K);
            end
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[i] <= 1'b0;
                else if (en)
                    vld_reg[i] <= v_in;
            end
            always_ff @(posedge clk)
            begin
                if (en)
                    st_reg[i] <= w_next;
            end
        end
    endgenerate

    assign out_vld  = vld_reg[DIV_STAGES-1];
    assign out_work = st_reg[DIV_STAGES-1];

endmodule

// ===== hw/rtl/cau_pack.sv =====
// Output stage: saturation, status and the output register.
// Depends on cau_pkg.
`timescale 1ns / 1ps

module cau_pack
    import cau_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  cau_work_t         in_work,
    output logic              out_vld,
    output logic [DATA_W-1:0] res_re,
    output logic [DATA_W-1:0] res_im,
    output logic [1:0]        status
);

    logic              vld_reg;
    logic [DATA_W-1:0] re_reg, im_reg, re_next, im_next;
    logic [1:0]        st_reg, st_next;

    function automatic logic [DATA_W:0] sat_part(input cau_part_t p, input logic is_div);
        logic [NUM_W-1:0]  m;
        logic [DATA_W-1:0] v;
        logic              s;
        if (!is_div)
            m = p.rem;
        else if (p.ovf)
            m = NUM_W'(1) << DATA_W;
        else
            m = NUM_W'(p.quo);
        s = 1'b0;
        if (!p.neg || m == '0)
        begin
            if (m > NUM_W'((1 << (DATA_W - 1)) - 1))
            begin
                m = NUM_W'((1 << (DATA_W - 1)) - 1);
                s = 1'b1;
            end
            v = m[DATA_W-1:0];
        end
        else
        begin
            if (m > NUM_W'(1 << (DATA_W - 1)))
            begin
                m = NUM_W'(1 << (DATA_W - 1));
                s = 1'b1;
            end
            v = ~m[DATA_W-1:0] + 1'b1;
        end
        return {s, v};
    endfunction

    always_comb
    begin
        logic [DATA_W:0] pr, pi;
        pr = sat_part(in_work.re, in_work.is_div);
        pi = sat_part(in_work.im, in_work.is_div);
        if (in_work.is_div && in_work.dz)
        begin
            re_next = '0;
            im_next = '0;
            st_next = ST_DIV0;
        end
        else
        begin
            re_next = pr[DATA_W-1:0];
            im_next = pi[DATA_W-1:0];
            st_next = (pr[DATA_W] || pi[DATA_W]) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            re_reg <= re_next;
            im_reg <= im_next;
            st_reg <= st_next;
        end
    end

    assign out_vld = vld_reg;
    assign res_re  = re_reg;
    assign res_im  = im_reg;
    assign status  = st_reg;

endmodule

// ===== hw/rtl/complex_arithmetic_unit_core.sv =====
// Complex arithmetic unit, top level: stream ports around the front end,
// divider and output stage. Depends on cau_pkg, cau_front, cau_divider, cau_pack.
`timescale 1ns / 1ps

// The unit adds, subtracts, multiplies or divides two complex Q8.8 operands and
// returns one saturated Q8.8 complex result with a status code for every item.
// It is a fixed pipeline of 21 register stages: three front stages (input,
// products, sums and divisor), one stage per quotient bit in the 17-stage
// divider, and the output register. Every operation takes the same path, so
// results leave in input order, and a new item is taken in every cycle that
// s_tready is high. When the output is not taken the whole pipe holds in
// place; s_tready is low only while a result waits in the output
// register and m_tready is low. Status is 0 for a clean result, 1 for a divide
// with a zero divisor (both parts then read zero) and 2 when a part saturated.

module complex_arithmetic_unit_core
    import cau_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // op[1:0], a_re[17:2], a_im[33:18], b_re[49:34],
                                   // b_im[65:50], zero fill [71:66]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // res_re[15:0], res_im[31:16], status[33:32],
                                   // zero fill [39:34]
);

    logic              en;
    logic              f_vld, d_vld, o_vld;
    cau_work_t         f_work, d_work;
    logic [DATA_W-1:0] res_re, res_im;
    logic [1:0]        status;

    // The pipe advances whenever the output register is empty or being emptied.
    assign en       = !o_vld || m_tready;
    assign s_tready = en;

    cau_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s_tvalid),
        .op       (s_tdata[1:0]),
        .a_re     (s_tdata[17:2]),
        .a_im     (s_tdata[33:18]),
        .b_re     (s_tdata[49:34]),
        .b_im     (s_tdata[65:50]),
        .out_vld  (f_vld),
        .out_work (f_work)
    );

    cau_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (f_vld),
        .in_work  (f_work),
        .out_vld  (d_vld),
        .out_work (d_work)
    );

    cau_pack u_pack (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (d_vld),
        .in_work (d_work),
        .out_vld (o_vld),
        .res_re  (res_re),
        .res_im  (res_im),
        .status  (status)
    );

    assign m_tvalid = o_vld;
    assign m_tdata  = {6'b0, status, res_im, res_re};

endmodule

// ===== bench/cau_checker.sv =====
// Checker for the complex arithmetic unit: watches both stream channels,
// predicts each result from the accepted item and compares it. Uses cau_pkg.
`timescale 1ns / 1ps

module cau_checker
    import cau_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    output int          fail_count,
    output int          pending,
    output int          result_count
);

    typedef struct packed {
        logic [15:0] re;
        logic [15:0] im;
        logic [1:0]  status;
    } cau_result_t;

    cau_result_t expected_results[$];

    // Clamp one part to the signed 16-bit range; flag any clamp.
    function automatic logic [15:0] clamp16(input longint v, inout bit sat);
        if (v > 32767)
        begin
            sat = 1;
            return 16'h7fff;
        end
        if (v < -32768)
        begin
            sat = 1;
            return 16'h8000;
        end
        return v[15:0];
    endfunction

    // Quotient num * 2^8 / den, truncated toward zero (exact in 64 bits).
    function automatic longint quotient(input longint num, input longint den);
        longint q;
        q = ((num < 0) ? -num : num) * 256 / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic cau_result_t complex_result(input logic [71:0] d);
        cau_result_t r;
        logic [1:0] op;
        longint a, b, c, e, re, im, den;
        bit sat;
        op = d[1:0];
        a = longint'($signed(d[17:2]));
        b = longint'($signed(d[33:18]));
        c = longint'($signed(d[49:34]));
        e = longint'($signed(d[65:50]));
        sat = 0;
        case (op)
            OP_ADD:
            begin
                re = a + c;
                im = b + e;
            end
            OP_SUB:
            begin
                re = a - c;
                im = b - e;
            end
            OP_MUL:
            begin
                // Arithmetic shift floors toward minus infinity.
                re = (a * c - b * e) >>> 8;
                im = (a * e + b * c) >>> 8;
            end
            default:
            begin
                den = c * c + e * e;
                if (den == 0)
                begin
                    r.re = '0;
                    r.im = '0;
                    r.status = ST_DIV0;
                    return r;
                end
                re = quotient(a * c + b * e, den);
                im = quotient(b * c - a * e, den);
            end
        endcase
        r.re = clamp16(re, sat);
        r.im = clamp16(im, sat);
        r.status = sat ? ST_SAT : ST_OK;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cau_result_t want;
        cau_result_t got;
        if (!rst_n)
        begin
            fail_count = 0;
            result_count <= 0;
            pending <= 0;
            expected_results.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_results.push_back(complex_result(s_tdata));
            if (m_tvalid && m_tready)
            begin
                result_count <= result_count + 1;
                got.re = m_tdata[15:0];
                got.im = m_tdata[31:16];
                got.status = m_tdata[33:32];
                if (expected_results.size() == 0)
                begin
                    $display("mismatch at %0t: result with nothing expected", $realtime);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.re !== want.re)
                        report_mismatch("res_re", got.re, want.re);
                    if (got.im !== want.im)
                        report_mismatch("res_im", got.im, want.im);
                    if (got.status !== want.status)
                        report_mismatch("status", {14'b0, got.status}, {14'b0, want.status});
                end
            end
            pending <= expected_results.size();
        end
    end

endmodule

// ===== bench/tb_complex_arithmetic_unit_core.sv =====
// Testbench top for the complex arithmetic unit: clock, reset, stimulus and verdict.
// Depends on cau_pkg, cau_checker and the unit's RTL.
`timescale 1ns / 1ps

module tb_complex_arithmetic_unit_core;
    import cau_pkg::*;

    localparam int RANDOM_ITEMS = 1600;
    localparam int CYCLE_LIMIT = 200000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [39:0] m_tdata;
    int          fail_count;
    int          pending;
    int          result_count;
    int          cycle_count = 0;
    int          item_count = 0;
    bit          quiet_tail = 0;

    complex_arithmetic_unit_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    cau_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending(pending), .result_count(result_count)
    );

    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: ready drops in random bursts, never during the quiet tail.
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            m_tready <= 1;
            repeat ($urandom_range(1, 40)) @(posedge clk);
            if (!quiet_tail && $urandom_range(0, 2) == 0)
            begin
                gap = $urandom_range(1, 13);
                m_tready <= 0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // Biased operand value: extremes, zero, small values or anything.
    function automatic logic [15:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'($signed($urandom_range(0, 1023)) - 512);
            4: return 16'($signed($urandom_range(0, 255)) - 128) << 8;
            default: return 16'($urandom);
        endcase
    endfunction

    // Hold one item until the unit takes it. Valid is left high; the caller
    // lowers it when no further item follows immediately.
    task automatic send_item(input logic [1:0] op, input logic [15:0] are,
                             input logic [15:0] aim, input logic [15:0] bre,
                             input logic [15:0] bim);
        s_tdata <= {6'b0, bim, bre, aim, are, op};
        s_tvalid <= 1;
        @(posedge clk iff s_tready);
        item_count++;
    endtask

    task automatic sender_gap();
        if (!quiet_tail && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    initial
    begin
        logic [1:0] op;
        logic [15:0] vb, vd;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed items: every operation, the field extremes, zero divisor,
        // saturation of sums, products and quotients.
        for (int k = 0; k < 4; k++)
        begin
            op = k[1:0];
            send_item(op, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
            send_item(op, 16'h0100, 16'h0200, 16'h0000, 16'h0000);
            send_item(op, 16'h8000, 16'h7fff, 16'h0001, 16'hffff);
            send_item(op, 16'hffff, 16'hffff, 16'h8000, 16'h8000);
        end
        send_item(OP_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_item(OP_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000);
        send_item(OP_MUL, 16'h5555, 16'haaaa, 16'haaaa, 16'h5555);
        send_item(OP_DIV, 16'h0300, 16'hfd00, 16'h0100, 16'h0100);

        // Pause until the pipe has drained once.
        s_tvalid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n > RANDOM_ITEMS - 200)
                quiet_tail = 1;
            op = 2'($urandom_range(0, 3));
            vb = pick_operand();
            vd = pick_operand();
            // A zero divisor now and then.
            if (op == OP_DIV && $urandom_range(0, 15) == 0)
            begin
                vb = '0;
                vd = '0;
            end
            send_item(op, pick_operand(), pick_operand(), vb, vd);
            sender_gap();
        end
        s_tvalid <= 0;
        @(posedge clk);

        while (pending != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        $display("Sent %0d items over all four operations, %0d results checked.",
                 item_count, result_count);
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/cau_pkg.sv
hw/rtl/cau_front.sv
hw/rtl/cau_divider.sv
hw/rtl/cau_pack.sv
hw/rtl/complex_arithmetic_unit_core.sv
bench/cau_checker.sv
bench/tb_complex_arithmetic_unit_core.sv
